// ===== rtl/bpt_pkg.sv =====
// Shared types and fixed constants for the Bezier point and tangent evaluator.
package bpt_pkg;

    localparam int CFG_DEG_W    = 3;
    localparam int CFG_DEG_RST  = 3;
    localparam int IDX_IN_W     = 3;
    localparam int TAN_EXTRA    = 5;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Per-cycle commands from the sequencer to both axis datapaths
    typedef struct packed {
        logic fill_wr;     // write store data into the work line
        logic sub_en;      // latch a and b - a from the line head
        logic mul_en;      // multiply the difference by the current factor
        logic step_wr;     // shift the line and write the interpolated value
        logic drop_shift;  // shift the line without a write
        logic pt_cap;      // capture the final interpolated value as the point
    } bpt_ctrl_t;

endpackage

// ===== rtl/bpt_lerp_unit.sv =====
// Shared interpolation unit: subtract and multiply are registered, then scale and add combinationally.
module bpt_lerp_unit #(
    parameter int COORD_BITS  = 32,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                          clk,
    input  logic                                          sub_en,
    input  logic                                          mul_en,
    input  logic signed [COORD_BITS-1:0]                  op_a,
    input  logic signed [COORD_BITS-1:0]                  op_b,
    input  logic        [T_FRAC_BITS:0]                   mul_k,
    output logic signed [COORD_BITS-1:0]                  res,
    output logic signed [COORD_BITS+bpt_pkg::TAN_EXTRA-1:0] tan
);
    import bpt_pkg::*;

    localparam int D_W = COORD_BITS + 1;
    localparam int K_W = T_FRAC_BITS + 2;
    localparam int P_W = D_W + K_W;

    logic signed [COORD_BITS-1:0] a_reg;
    logic signed [D_W-1:0]        d_reg;
    logic signed [P_W-1:0]        prod_reg;
    logic signed [P_W-1:0]        scaled;
    logic signed [P_W-1:0]        sum;

    always_ff @(posedge clk)
    begin
        if (sub_en)
        begin
            a_reg <= op_a;
            d_reg <= $signed({op_b[COORD_BITS-1], op_b}) - $signed({op_a[COORD_BITS-1], op_a});
        end
        if (mul_en)
        begin
            prod_reg <= P_W'(d_reg * $signed({1'b0, mul_k}));
        end
    end

    // Arithmetic shift floors toward minus infinity; the sum stays between a and b
    always_comb
    begin
        scaled = prod_reg >>> T_FRAC_BITS;
        sum    = $signed({{(P_W-COORD_BITS){a_reg[COORD_BITS-1]}}, a_reg}) + scaled;
    end

    assign res = sum[COORD_BITS-1:0];
    assign tan = prod_reg[COORD_BITS+TAN_EXTRA-1:0];

endmodule

// ===== rtl/bpt_axis.sv =====
// One coordinate axis: de Casteljau work line and its interpolation unit.
module bpt_axis #(
    parameter int COORD_BITS  = 32,
    parameter int T_FRAC_BITS = 16,
    parameter int DEPTH       = 8,
    parameter int IDX_W       = 3
) (
    input  logic                                            clk,
    input  bpt_pkg::bpt_ctrl_t                              ctrl,
    input  logic        [IDX_W-1:0]                         wr_idx,
    input  logic signed [COORD_BITS-1:0]                    fill_data,
    input  logic        [T_FRAC_BITS:0]                     mul_k,
    output logic signed [COORD_BITS-1:0]                    pt,
    output logic signed [COORD_BITS+bpt_pkg::TAN_EXTRA-1:0] tan
);
    import bpt_pkg::*;

    logic signed [COORD_BITS-1:0] line_reg  [DEPTH];
    logic signed [COORD_BITS-1:0] line_next [DEPTH];
    logic signed [COORD_BITS-1:0] pt_reg;
    logic signed [COORD_BITS-1:0] lerp_res;

    bpt_lerp_unit #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_lerp (
        .clk    (clk),
        .sub_en (ctrl.sub_en),
        .mul_en (ctrl.mul_en),
        .op_a   (line_reg[0]),
        .op_b   (line_reg[1]),
        .mul_k  (mul_k),
        .res    (lerp_res),
        .tan    (tan)
    );

    // The pair under work always sits at the head; new values land behind the level
    always_comb
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            line_next[k] = line_reg[k];
        end
        if (ctrl.step_wr || ctrl.drop_shift)
        begin
            for (int k = 0; k < DEPTH - 1; k++)
            begin
                line_next[k] = line_reg[k+1];
            end
        end
        if (ctrl.step_wr)
        begin
            line_next[wr_idx] = lerp_res;
        end
        else if (ctrl.fill_wr)
        begin
            line_next[wr_idx] = fill_data;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DEPTH; k++)
        begin
            line_reg[k] <= line_next[k];
        end
        if (ctrl.pt_cap)
        begin
            pt_reg <= lerp_res;
        end
    end

    assign pt = pt_reg;

endmodule

// ===== rtl/bpt_seq.sv =====
// Sequencer: fills the work lines, steps the levels and issues the tangent multiply.
module bpt_seq #(
    parameter int T_FRAC_BITS = 16,
    parameter int IDX_W       = 3
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [IDX_W-1:0]         deg,
    input  logic [T_FRAC_BITS:0]     t_sat,
    input  logic                     out_free,
    output logic                     idle,
    output logic                     cap,
    output logic [IDX_W-1:0]         rd_addr,
    output logic [IDX_W-1:0]         wr_idx,
    output logic [T_FRAC_BITS:0]     mul_k,
    output bpt_pkg::bpt_ctrl_t       ctrl
);
    import bpt_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_FILL_RD = 4'd1;
    localparam logic [3:0] S_FILL_WR = 4'd2;
    localparam logic [3:0] S_SUB     = 4'd3;
    localparam logic [3:0] S_MUL     = 4'd4;
    localparam logic [3:0] S_ADD     = 4'd5;
    localparam logic [3:0] S_DROP    = 4'd6;
    localparam logic [3:0] S_TAN     = 4'd7;
    localparam logic [3:0] S_FIN     = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] lvl_reg, lvl_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lvl_next   = lvl_reg;
        ctrl       = '0;
        cap        = 1'b0;
        wr_idx     = lvl_reg;
        mul_k      = t_sat;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cnt_next   = '0;
                    state_next = S_FILL_RD;
                end
            end
            S_FILL_RD:
            begin
                state_next = S_FILL_WR;
            end
            S_FILL_WR:
            begin
                ctrl.fill_wr = 1'b1;
                wr_idx       = cnt_reg;
                if (cnt_reg == deg)
                begin
                    cnt_next   = '0;
                    lvl_next   = deg;
                    state_next = S_SUB;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_FILL_RD;
                end
            end
            S_SUB:
            begin
                ctrl.sub_en = 1'b1;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                ctrl.mul_en = 1'b1;
                state_next  = S_ADD;
            end
            S_ADD:
            begin
                if (lvl_reg == IDX_W'(1))
                begin
                    ctrl.pt_cap = 1'b1;
                    state_next  = S_TAN;
                end
                else
                begin
                    ctrl.step_wr = 1'b1;
                    if (cnt_reg == IDX_W'(lvl_reg - 1'b1))
                    begin
                        state_next = S_DROP;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_SUB;
                    end
                end
            end
            S_DROP:
            begin
                // Discard the last point of the finished level
                ctrl.drop_shift = 1'b1;
                lvl_next        = lvl_reg - 1'b1;
                cnt_next        = '0;
                state_next      = S_SUB;
            end
            S_TAN:
            begin
                ctrl.mul_en = 1'b1;
                mul_k       = (T_FRAC_BITS+1)'(deg);
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cap        = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            lvl_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            lvl_reg   <= lvl_next;
        end
    end

    assign idle    = (state_reg == S_IDLE);
    assign rd_addr = cnt_reg;

endmodule

// ===== rtl/bezier_point_and_tangent_eval_core.sv =====
// Top level: control point store, degree register, handshakes and result register.
//
//  channel | direction | signals                                  | transfer when
//  --------+-----------+------------------------------------------+-----------------------
//  in      | input     | operation point_index coord_x coord_y    | in_valid & in_ready
//          |           | param_t                                  |
//  out     | output    | point_x point_y tangent_x tangent_y      | out_valid & out_ready
//  cfg     | input     | cfg_data (curve degree)                  | cfg_valid & cfg_ready
//
// A load writes the store directly. An evaluation at degree d (after clamping to
// 1..MAX_DEGREE) reads the store into the work line one entry at a time, each entry
// through a read state and a write state, and every interpolation steps through
// subtract, multiply and add on the one multiplier per axis. in_ready is low while an
// evaluation runs. A result waiting in the output register holds the sequencer at its
// last step, and in_ready stays low meanwhile, so no load or evaluation is taken. Reset
// clears control state and sets the degree to 3; the store holds no reset value.
module bezier_point_and_tangent_eval_core #(
    parameter int MAX_DEGREE  = 7,
    parameter int COORD_BITS  = 32,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             in_valid,
    output logic                                             in_ready,
    input  logic                                             operation,
    input  logic        [bpt_pkg::IDX_IN_W-1:0]              point_index,
    input  logic signed [COORD_BITS-1:0]                     coord_x,
    input  logic signed [COORD_BITS-1:0]                     coord_y,
    input  logic        [T_FRAC_BITS:0]                      param_t,
    output logic                                             out_valid,
    input  logic                                             out_ready,
    output logic signed [COORD_BITS-1:0]                     point_x,
    output logic signed [COORD_BITS-1:0]                     point_y,
    output logic signed [COORD_BITS+bpt_pkg::TAN_EXTRA-1:0]  tangent_x,
    output logic signed [COORD_BITS+bpt_pkg::TAN_EXTRA-1:0]  tangent_y,
    input  logic                                             cfg_valid,
    output logic                                             cfg_ready,
    input  logic        [bpt_pkg::CFG_DEG_W-1:0]             cfg_data
);
    import bpt_pkg::*;

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int TAN_W = COORD_BITS + TAN_EXTRA;
    localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

    logic [CFG_DEG_W-1:0]         degree_reg;
    logic [IDX_W-1:0]             deg_eff;
    logic [T_FRAC_BITS:0]         t_reg;
    logic                         in_xfer;
    logic                         load_wr;
    logic                         start;
    logic                         idle;
    logic                         cap;
    logic                         out_free;
    logic [IDX_W-1:0]             rd_addr;
    logic [IDX_W-1:0]             wr_idx;
    logic [T_FRAC_BITS:0]         mul_k;
    bpt_ctrl_t                    ctrl;

    logic signed [COORD_BITS-1:0] ctrl_x_mem [DEPTH];
    logic signed [COORD_BITS-1:0] ctrl_y_mem [DEPTH];
    logic signed [COORD_BITS-1:0] rd_x_reg;
    logic signed [COORD_BITS-1:0] rd_y_reg;

    logic signed [COORD_BITS-1:0] pt_x, pt_y;
    logic signed [TAN_W-1:0]      tan_x, tan_y;

    logic                         out_valid_reg;
    logic signed [COORD_BITS-1:0] point_x_reg, point_y_reg;
    logic signed [TAN_W-1:0]      tangent_x_reg, tangent_y_reg;

    assign in_ready  = idle;
    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid && in_ready;
    assign start     = in_xfer && (operation == OP_EVAL);
    // Drop loads aimed past the store
    assign load_wr   = in_xfer && (operation == OP_LOAD) && (int'(point_index) <= MAX_DEGREE);
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        if (degree_reg == '0)
        begin
            deg_eff = IDX_W'(1);
        end
        else if (int'(degree_reg) > MAX_DEGREE)
        begin
            deg_eff = IDX_W'(MAX_DEGREE);
        end
        else
        begin
            deg_eff = IDX_W'(degree_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= CFG_DEG_W'(CFG_DEG_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            degree_reg <= cfg_data;
        end
    end

    // Saturate t above one on the way in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            t_reg <= (param_t > T_ONE) ? T_ONE : param_t;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            ctrl_x_mem[IDX_W'(point_index)] <= coord_x;
            ctrl_y_mem[IDX_W'(point_index)] <= coord_y;
        end
        rd_x_reg <= ctrl_x_mem[rd_addr];
        rd_y_reg <= ctrl_y_mem[rd_addr];
    end

    bpt_seq #(
        .T_FRAC_BITS (T_FRAC_BITS),
        .IDX_W       (IDX_W)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .deg      (deg_eff),
        .t_sat    (t_reg),
        .out_free (out_free),
        .idle     (idle),
        .cap      (cap),
        .rd_addr  (rd_addr),
        .wr_idx   (wr_idx),
        .mul_k    (mul_k),
        .ctrl     (ctrl)
    );

    bpt_axis #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS),
        .DEPTH       (DEPTH),
        .IDX_W       (IDX_W)
    ) u_axis_x (
        .clk       (clk),
        .ctrl      (ctrl),
        .wr_idx    (wr_idx),
        .fill_data (rd_x_reg),
        .mul_k     (mul_k),
        .pt        (pt_x),
        .tan       (tan_x)
    );

    bpt_axis #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS),
        .DEPTH       (DEPTH),
        .IDX_W       (IDX_W)
    ) u_axis_y (
        .clk       (clk),
        .ctrl      (ctrl),
        .wr_idx    (wr_idx),
        .fill_data (rd_y_reg),
        .mul_k     (mul_k),
        .pt        (pt_y),
        .tan       (tan_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cap)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap)
        begin
            point_x_reg   <= pt_x;
            point_y_reg   <= pt_y;
            tangent_x_reg <= tan_x;
            tangent_y_reg <= tan_y;
        end
    end

    assign out_valid = out_valid_reg;
    assign point_x   = point_x_reg;
    assign point_y   = point_y_reg;
    assign tangent_x = tangent_x_reg;
    assign tangent_y = tangent_y_reg;

    a_cap_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cap |-> (!out_valid_reg || out_ready))
        else $error("result captured over an untaken result");

    a_eval_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !in_ready)
        else $error("evaluation did not start the sequencer");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (operation == OP_LOAD)) |=> in_ready)
        else $error("load left the block busy");

    a_cap_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cap |=> (in_ready && out_valid))
        else $error("capture did not present a result and free the input");

endmodule

// ===== bench/bezier_point_and_tangent_eval_core_tb.sv =====
// Self-checking bench for the Bezier point and tangent evaluator.
`timescale 1ns / 1ps

module bezier_point_and_tangent_eval_core_tb;

    import bpt_pkg::*;

    localparam int MAX_DEG     = 7;
    localparam int COORD_W     = 32;
    localparam int T_FRAC      = 16;
    localparam int TAN_W       = COORD_W + TAN_EXTRA;
    localparam int T_UNIT      = 1 << T_FRAC;
    localparam int DRAIN_WAIT  = 128;
    localparam int STALL_LIMIT = 3000;
    localparam int PRESS_HOLD  = 400;
    localparam int SEG_ITEMS   = 70;
    localparam int NUM_SEGS    = 10;

    typedef struct {
        logic                      op;
        logic [IDX_IN_W-1:0]       idx;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [T_FRAC:0]           t;
    } curve_item_t;

    typedef struct {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [TAN_W-1:0]   tx;
        logic signed [TAN_W-1:0]   ty;
    } curve_point_t;

    // Tracks the control points and degree, and the curve points still owed by the block
    class curve_tracker;
        logic signed [COORD_W-1:0] ctrl_x[MAX_DEG+1];
        logic signed [COORD_W-1:0] ctrl_y[MAX_DEG+1];
        logic [CFG_DEG_W-1:0]      degree;
        curve_point_t              owed_points[$];
        int                        mismatches;

        function new();
            degree = CFG_DEG_W'(CFG_DEG_RST);
            mismatches = 0;
        endfunction

        function void set_degree(logic [CFG_DEG_W-1:0] d);
            degree = d;
        endfunction

        function int pending();
            return owed_points.size();
        endfunction

        // a + floor((b - a) * t / 2^T_FRAC); t is already clamped to 1.0
        function longint interp(longint a, longint b, longint t);
            longint d;
            d = b - a;
            return a + ((d * t) >>> T_FRAC);
        endfunction

        function void de_casteljau(input logic signed [COORD_W-1:0] pts[MAX_DEG+1],
                                   input int deg, input longint t,
                                   output longint pt, output longint slope);
            longint line[MAX_DEG+1];
            for (int i = 0; i <= deg; i++)
                line[i] = longint'(pts[i]);
            for (int r = deg; r >= 2; r--)
                for (int i = 0; i < r; i++)
                    line[i] = interp(line[i], line[i+1], t);
            slope = deg * (line[1] - line[0]);
            pt = interp(line[0], line[1], t);
        endfunction

        function void take_item(curve_item_t it);
            curve_point_t res;
            longint       t, px, py, sx, sy;
            int           deg;
            if (it.op == OP_LOAD)
            begin
                if (int'(it.idx) <= MAX_DEG)
                begin
                    ctrl_x[it.idx] = it.cx;
                    ctrl_y[it.idx] = it.cy;
                end
                return;
            end
            t = (int'(it.t) > T_UNIT) ? longint'(T_UNIT) : longint'(it.t);
            deg = (degree == '0) ? 1 : ((int'(degree) > MAX_DEG) ? MAX_DEG : int'(degree));
            de_casteljau(ctrl_x, deg, t, px, sx);
            de_casteljau(ctrl_y, deg, t, py, sy);
            res.px = COORD_W'(px);
            res.py = COORD_W'(py);
            res.tx = TAN_W'(sx);
            res.ty = TAN_W'(sy);
            owed_points = {owed_points, res};
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH %s", $time, msg);
            mismatches++;
        endtask

        task check_point(curve_point_t got);
            curve_point_t want;
            if (owed_points.size() == 0)
            begin
                report("result with no evaluation outstanding");
                return;
            end
            want = owed_points.pop_front();
            if (got.px !== want.px)
                report($sformatf("point_x got %0d want %0d", got.px, want.px));
            if (got.py !== want.py)
                report($sformatf("point_y got %0d want %0d", got.py, want.py));
            if (got.tx !== want.tx)
                report($sformatf("tangent_x got %0d want %0d", got.tx, want.tx));
            if (got.ty !== want.ty)
                report($sformatf("tangent_y got %0d want %0d", got.ty, want.ty));
        endtask
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      operation;
    logic [IDX_IN_W-1:0]       point_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [T_FRAC:0]           param_t;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [TAN_W-1:0]   tangent_x;
    logic signed [TAN_W-1:0]   tangent_y;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_DEG_W-1:0]      cfg_data;

    curve_tracker tracker;
    int           tx_idle_pct;
    int           rx_idle_pct;
    int           hold_left;
    int           stall_count;

    bezier_point_and_tangent_eval_core #(
        .MAX_DEGREE  (MAX_DEG),
        .COORD_BITS  (COORD_W),
        .T_FRAC_BITS (T_FRAC)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .point_index (point_index),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .param_t     (param_t),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .tangent_x   (tangent_x),
        .tangent_y   (tangent_y),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random ready, or a counted hold-off when one is requested
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Note every transfer at the edge where it happens
    always @(posedge clk)
    begin
        curve_item_t  it;
        curve_point_t got;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.set_degree(cfg_data);
            if (in_valid && in_ready)
            begin
                it.op  = operation;
                it.idx = point_index;
                it.cx  = coord_x;
                it.cy  = coord_y;
                it.t   = param_t;
                tracker.take_item(it);
            end
            if (out_valid && out_ready)
            begin
                got.px = point_x;
                got.py = point_y;
                got.tx = tangent_x;
                got.ty = tangent_y;
                tracker.check_point(got);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_count <= 0;
        else
        begin
            stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    task send_item(curve_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        operation   = it.op;
        point_index = it.idx;
        coord_x     = it.cx;
        coord_y     = it.cy;
        param_t     = it.t;
        in_valid    = 1'b1;
        do @(posedge clk); while (!in_ready);
    endtask

    task load_point(int idx, logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
        curve_item_t it;
        it.op  = OP_LOAD;
        it.idx = IDX_IN_W'(idx);
        it.cx  = x;
        it.cy  = y;
        it.t   = (T_FRAC+1)'($urandom);
        send_item(it);
    endtask

    task eval_at(int t);
        curve_item_t it;
        it.op  = OP_EVAL;
        it.idx = IDX_IN_W'($urandom);
        it.cx  = COORD_W'($urandom);
        it.cy  = COORD_W'($urandom);
        it.t   = (T_FRAC+1)'(t);
        send_item(it);
    endtask

    // Drop valid, wait for every owed result, then let the sequencer settle
    task wait_for_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task write_degree(int d);
        wait_for_idle();
        @(negedge clk);
        cfg_data  = CFG_DEG_W'(d);
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(5))
            0: return {1'b1, {(COORD_W-1){1'b0}}};
            1: return {1'b0, {(COORD_W-1){1'b1}}};
            2: return COORD_W'($urandom_range(0, 1 << 21)) - COORD_W'(1 << 20);
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function logic [T_FRAC:0] rand_param();
        case ($urandom_range(9))
            0: return '0;
            1: return (T_FRAC+1)'(T_UNIT);
            2: return (T_FRAC+1)'($urandom_range(T_UNIT + 1, 2 * T_UNIT - 1));
            default: return (T_FRAC+1)'($urandom_range(0, T_UNIT));
        endcase
    endfunction

    function curve_item_t make_item();
        curve_item_t it;
        it.idx = IDX_IN_W'($urandom);
        it.cx  = COORD_W'($urandom);
        it.cy  = COORD_W'($urandom);
        it.t   = (T_FRAC+1)'($urandom);
        if ($urandom_range(99) < 35)
        begin
            it.op = OP_LOAD;
            it.cx = rand_coord();
            it.cy = rand_coord();
        end
        else
        begin
            it.op = OP_EVAL;
            it.t  = rand_param();
        end
        return it;
    endfunction

    initial
    begin
        int seg_degrees[NUM_SEGS] = '{7, 0, 1, 2, 4, 5, 6, 7, 3, 5};
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        operation   = OP_LOAD;
        point_index = '0;
        coord_x     = '0;
        coord_y     = '0;
        param_t     = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        hold_left   = 0;
        stall_count = 0;
        tx_idle_pct = 29;
        rx_idle_pct = 88;
        tracker     = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Fill the whole store, mostly with extreme points, before any evaluation
        load_point(0, 32'sh8000_0000, 32'sh7fff_ffff);
        load_point(1, 32'sh7fff_ffff, 32'sh8000_0000);
        load_point(2, 32'sh0000_0000, -32'sd1);
        load_point(3, -32'sd1, 32'sh0000_0000);
        load_point(4, 32'sh8000_0000, 32'sh8000_0000);
        load_point(5, 32'sh7fff_ffff, 32'sh7fff_ffff);
        load_point(6, 32'sh0001_0000, -32'sh0001_0000);
        load_point(7, 32'sh1234_5678, -32'sh1234_5678);
        // Endpoints, near-endpoints, midpoint, and t above one
        eval_at(0);
        eval_at(T_UNIT);
        eval_at(1);
        eval_at(T_UNIT - 1);
        eval_at(T_UNIT / 2);
        eval_at(2 * T_UNIT - 1);
        eval_at(T_UNIT + 1);

        for (int seg = 0; seg < NUM_SEGS; seg++)
        begin
            write_degree(seg_degrees[seg]);
            if (seg < 4)
            begin
                tx_idle_pct = 29;
                rx_idle_pct = 88;
            end
            else if (seg < 7)
            begin
                tx_idle_pct = 88;
                rx_idle_pct = 29;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (seg == 0)
            begin
                eval_at(0);
                eval_at(T_UNIT);
                eval_at(3 * T_UNIT / 4);
            end
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                // Stall the output while the sender keeps pushing
                if (seg == 7 && n == 10)
                    hold_left = PRESS_HOLD;
                send_item(make_item());
            end
        end

        wait_for_idle();
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bpt_pkg.sv
rtl/bpt_lerp_unit.sv
rtl/bpt_axis.sv
rtl/bpt_seq.sv
rtl/bezier_point_and_tangent_eval_core.sv
bench/bezier_point_and_tangent_eval_core_tb.sv
